/* sv/csl_pkg.sv */
package csl_pkg;

    // velocity field width default, step register width
    localparam int VEL_W_DEF = 24;
    localparam int STEP_W    = 20;
    localparam int CNT_W     = $clog2(STEP_W);

    // APB register map (word index)
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_LIN_ACC = 2'd0;
    localparam logic [1:0] REG_LIN_DEC = 2'd1;
    localparam logic [1:0] REG_ANG_ACC = 2'd2;
    localparam logic [1:0] REG_ANG_DEC = 2'd3;

    localparam logic [STEP_W-1:0] LIN_ACC_RST = STEP_W'(546);
    localparam logic [STEP_W-1:0] LIN_DEC_RST = STEP_W'(2185);
    localparam logic [STEP_W-1:0] ANG_ACC_RST = STEP_W'(32768);
    localparam logic [STEP_W-1:0] ANG_DEC_RST = STEP_W'(32768);

    typedef struct packed {
        logic [STEP_W-1:0] lin_acc;
        logic [STEP_W-1:0] lin_dec;
        logic [STEP_W-1:0] ang_acc;
        logic [STEP_W-1:0] ang_dec;
    } t_steps;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_DIV,
        S_UPD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic             load;   // capture word, fold signs
        logic             mul;    // one shift-add step of both products
        logic             cmp;    // pick slow axis, clear divider
        logic             div;    // one quotient bit of the scaled step
        logic             upd;    // move axes, store state, load output
        logic [CNT_W-1:0] idx;    // bit index for mul/div
    } t_dp_cmd;

endpackage

/* sv/csl_cfg.sv */
module csl_cfg
    import csl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_steps             o_steps
);

    t_steps r_steps;
    t_steps n_steps;
    logic   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        n_steps = r_steps;
        if (wr_en) begin
            case (paddr[3:2])
                REG_LIN_ACC: n_steps.lin_acc = pwdata[STEP_W-1:0];
                REG_LIN_DEC: n_steps.lin_dec = pwdata[STEP_W-1:0];
                REG_ANG_ACC: n_steps.ang_acc = pwdata[STEP_W-1:0];
                REG_ANG_DEC: n_steps.ang_dec = pwdata[STEP_W-1:0];
                default:     n_steps = r_steps;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps.lin_acc <= LIN_ACC_RST;
            r_steps.lin_dec <= LIN_DEC_RST;
            r_steps.ang_acc <= ANG_ACC_RST;
            r_steps.ang_dec <= ANG_DEC_RST;
        end else begin
            r_steps <= n_steps;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LIN_ACC: prdata = 32'(r_steps.lin_acc);
            REG_LIN_DEC: prdata = 32'(r_steps.lin_dec);
            REG_ANG_ACC: prdata = 32'(r_steps.ang_acc);
            REG_ANG_DEC: prdata = 32'(r_steps.ang_dec);
            default:     prdata = '0;
        endcase
    end

    assign o_steps = r_steps;

endmodule

/* sv/csl_ctrl.sv */
module csl_ctrl
    import csl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_dp_cmd o_cmd
);

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(STEP_W - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_vld, n_out_vld;
    logic             upd_go;

    // result register free, or being drained this cycle
    assign upd_go = !r_out_vld || i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_s_tvalid) n_state = S_MUL;
            S_MUL:  if (r_cnt == '0) n_state = S_CMP;
            S_CMP:  n_state = S_DIV;
            S_DIV:  if (r_cnt == '0) n_state = S_UPD;
            S_UPD:  if (upd_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.idx  = r_cnt;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_MUL: o_cmd.mul = 1'b1;
            S_CMP: o_cmd.cmp = 1'b1;
            S_DIV: o_cmd.div = 1'b1;
            S_UPD: o_cmd.upd = upd_go;
            default: o_s_tready = 1'b0;
        endcase
    end

    // bit counter, counts down from the step MSB
    always_comb begin
        n_cnt = r_cnt;
        case (r_state)
            S_IDLE: n_cnt = LAST_BIT;
            S_MUL:  n_cnt = (r_cnt == '0) ? LAST_BIT : r_cnt - 1'b1;
            S_CMP:  n_cnt = LAST_BIT;
            S_DIV:  n_cnt = (r_cnt == '0) ? LAST_BIT : r_cnt - 1'b1;
            default: n_cnt = LAST_BIT;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.upd) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= LAST_BIT;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_m_tvalid = r_out_vld;

endmodule

/* sv/csl_dp.sv */
module csl_dp
    import csl_pkg::*;
#(
    parameter int VEL_WIDTH = VEL_W_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_dp_cmd                              i_cmd,
    input  t_steps                               i_steps,
    input  logic [((2*VEL_WIDTH+7)/8)*8-1:0]     i_tdata,
    output logic [((2*VEL_WIDTH+7)/8)*8-1:0]     o_tdata
);

    localparam int W   = VEL_WIDTH;
    localparam int TDW = ((2*VEL_WIDTH+7)/8)*8;
    localparam int EW  = VEL_WIDTH + 23;   // headroom for folds, steps, moves
    localparam int PW  = VEL_WIDTH + 20;   // |err| * step
    localparam int NW  = VEL_WIDTH + 1;    // |err|

    localparam logic signed [EW-1:0] VMAX = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] VMIN = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    // persistent velocities
    logic [W-1:0] r_cur_l, r_cur_a;

    // per-item working registers (folded domain)
    logic signed [EW-1:0] r_tl, r_ta, r_cl, r_ca, r_el, r_ea;
    logic                 r_flip_l, r_flip_a;
    logic [NW-1:0]        r_nl, r_na;
    logic [STEP_W-1:0]    r_dl, r_da, r_sl, r_sa;
    logic [PW-1:0]        r_xl, r_xa, r_rem;
    logic [STEP_W-1:0]    r_q;
    logic                 r_lin_slow;
    logic [TDW-1:0]       r_out;

    // effective steps, zero reads as one
    logic [STEP_W-1:0] la, ld, aa, ad;
    assign la = (i_steps.lin_acc == '0) ? STEP_W'(1) : i_steps.lin_acc;
    assign ld = (i_steps.lin_dec == '0) ? STEP_W'(1) : i_steps.lin_dec;
    assign aa = (i_steps.ang_acc == '0) ? STEP_W'(1) : i_steps.ang_acc;
    assign ad = (i_steps.ang_dec == '0) ? STEP_W'(1) : i_steps.ang_dec;

    // ---------------- load: fold signs ----------------
    logic signed [EW-1:0] tl_x, ta_x, cl_x, ca_x;
    logic signed [EW-1:0] ftl, fta, fcl, fca, el, ea;
    logic                 flip_l, flip_a;

    assign tl_x = {{(EW-W){i_tdata[W-1]}},   i_tdata[W-1:0]};
    assign ta_x = {{(EW-W){i_tdata[2*W-1]}}, i_tdata[2*W-1:W]};
    assign cl_x = {{(EW-W){r_cur_l[W-1]}},   r_cur_l};
    assign ca_x = {{(EW-W){r_cur_a[W-1]}},   r_cur_a};

    assign flip_l = tl_x[EW-1];
    assign flip_a = ta_x[EW-1];
    assign ftl = flip_l ? -tl_x : tl_x;
    assign fcl = flip_l ? -cl_x : cl_x;
    assign fta = flip_a ? -ta_x : ta_x;
    assign fca = flip_a ? -ca_x : ca_x;
    assign el  = ftl - fcl;
    assign ea  = fta - fca;

    // ---------------- mul: MSB-first shift-add ----------------
    logic [PW-1:0] add_l, add_a;
    assign add_l = r_da[i_cmd.idx] ? PW'(r_nl) : '0;
    assign add_a = r_dl[i_cmd.idx] ? PW'(r_na) : '0;

    // ---------------- div: floor(s * x / y), radix-2 with digit 0..2 ----------------
    logic [PW-1:0]     dv_x, dv_y;
    logic [STEP_W-1:0] dv_s;
    logic [PW+1:0]     dv_t, dv_y1, dv_y2;
    logic [PW-1:0]     n_rem;
    logic [1:0]        dv_dig;
    logic [STEP_W:0]   q_w;

    assign dv_x  = r_lin_slow ? r_xa : r_xl;
    assign dv_y  = r_lin_slow ? r_xl : r_xa;
    assign dv_s  = r_lin_slow ? r_sa : r_sl;
    assign dv_t  = {r_rem, 1'b0} + (dv_s[i_cmd.idx] ? (PW+2)'(dv_x) : '0);
    assign dv_y1 = (PW+2)'(dv_y);
    assign dv_y2 = {1'b0, dv_y, 1'b0};

    always_comb begin
        if (dv_t >= dv_y2) begin
            n_rem  = PW'(dv_t - dv_y2);
            dv_dig = 2'd2;
        end else if (dv_t >= dv_y1) begin
            n_rem  = PW'(dv_t - dv_y1);
            dv_dig = 2'd1;
        end else begin
            n_rem  = PW'(dv_t);
            dv_dig = 2'd0;
        end
    end
    assign q_w = {r_q, 1'b0} + (STEP_W+1)'(dv_dig);

    // ---------------- upd: move both axes ----------------
    logic [STEP_W-1:0]    q_eff, amt_l, amt_a;
    logic signed [EW-1:0] la_x, ld_x, aa_x, ad_x, amt_l_x, amt_a_x;
    logic signed [EW-1:0] mv_l, mv_a, uf_l, uf_a, st_l, st_a;
    logic [W-1:0]         neg_a;

    assign q_eff = (dv_y == '0) ? '0 : r_q;   // both times zero
    assign amt_l = r_lin_slow ? r_sl : q_eff;
    assign amt_a = r_lin_slow ? q_eff : r_sa;

    assign la_x    = EW'(la);
    assign ld_x    = EW'(ld);
    assign aa_x    = EW'(aa);
    assign ad_x    = EW'(ad);
    assign amt_l_x = EW'(amt_l);
    assign amt_a_x = EW'(amt_a);

    always_comb begin
        if (r_cl[EW-1]) begin
            mv_l = r_cl + amt_l_x;
        end else if (!r_el[EW-1]) begin
            mv_l = (r_el < la_x) ? r_tl : r_cl + amt_l_x;
        end else begin
            mv_l = (-r_el < ld_x) ? r_tl : r_cl - amt_l_x;
        end
        if (r_ca[EW-1]) begin
            mv_a = r_ca + amt_a_x;
        end else if (!r_ea[EW-1]) begin
            mv_a = (r_ea < aa_x) ? r_ta : r_ca + amt_a_x;
        end else begin
            mv_a = (-r_ea < ad_x) ? r_ta : r_ca - amt_a_x;
        end
    end

    assign uf_l = r_flip_l ? -mv_l : mv_l;
    assign uf_a = r_flip_a ? -mv_a : mv_a;
    assign st_l = (uf_l > VMAX) ? VMAX : ((uf_l < VMIN) ? VMIN : uf_l);
    assign st_a = (uf_a > VMAX) ? VMAX : ((uf_a < VMIN) ? VMIN : uf_a);
    assign neg_a = (st_a[W-1:0] == WMIN) ? WMAX : W'(-st_a[W-1:0]);

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_l <= '0;
            r_cur_a <= '0;
        end else if (i_cmd.upd) begin
            r_cur_l <= st_l[W-1:0];
            r_cur_a <= st_a[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_flip_l <= flip_l;
            r_flip_a <= flip_a;
            r_tl     <= ftl;
            r_ta     <= fta;
            r_cl     <= fcl;
            r_ca     <= fca;
            r_el     <= el;
            r_ea     <= ea;
            r_nl     <= NW'(el[EW-1] ? -el : el);
            r_na     <= NW'(ea[EW-1] ? -ea : ea);
            r_dl     <= el[EW-1] ? ld : la;
            r_da     <= ea[EW-1] ? ad : aa;
            r_sl     <= (fcl[EW-1] || el[EW-1]) ? ld : la;
            r_sa     <= (fca[EW-1] || ea[EW-1]) ? ad : aa;
            r_xl     <= '0;
            r_xa     <= '0;
        end
        if (i_cmd.mul) begin
            r_xl <= {r_xl[PW-2:0], 1'b0} + add_l;
            r_xa <= {r_xa[PW-2:0], 1'b0} + add_a;
        end
        if (i_cmd.cmp) begin
            r_lin_slow <= (r_xl > r_xa);
            r_rem      <= '0;
            r_q        <= '0;
        end
        if (i_cmd.div) begin
            r_rem <= n_rem;
            r_q   <= q_w[STEP_W-1:0];
        end
        if (i_cmd.upd) begin
            r_out <= TDW'({neg_a, st_l[W-1:0]});
        end
    end

    assign o_tdata = r_out;

endmodule

/* sv/coordinated_velocity_slew_limiter_top.sv */
// Two-axis coordinated velocity slew limiter.
//
// Input stream (s_axis): one word per control period, tdata = target_linear
// (low VEL_WIDTH bits) then target_angular, signed Q8.16, zero-padded to bytes.
// Output stream (m_axis): one word per input word, tdata = linear_out then
// angular_out (angular negated), both saturated to VEL_WIDTH signed.
// APB port: four 20-bit step registers at 0x0/0x4/0x8/0xC (linear accel,
// linear decel, angular accel, angular decel); write only while idle.
//
// Sequence: a word is taken, then shift-add steps (S_MUL) form both time products,
// S_CMP picks the slow axis, the divider (S_DIV) works out the scaled step (one
// quotient bit per cycle), and S_UPD moves both axes and loads the result. A new
// word is taken only in idle, after the previous word has been moved in S_UPD;
// the multiplier and the divider both work one bit per cycle.
// The result sits in an output register, so the next word is taken while it
// waits; if the receiver stalls longer, the block holds in its final step.
// Reset (synchronous, active low) zeroes both held velocities and loads the
// default step values; no output is pending after reset.
module coordinated_velocity_slew_limiter_top
    import csl_pkg::*;
#(
    parameter int VEL_WIDTH = VEL_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // s_axis tdata: [target_linear, target_angular] from bit 0 up
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [((2*VEL_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // m_axis tdata: [linear_out, angular_out] from bit 0 up
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [((2*VEL_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // APB configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [PADDR_W-1:0]               paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    t_steps  steps;
    t_dp_cmd cmd;

    // step registers
    csl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_steps (steps)
    );

    // sequencer: handshakes and per-cycle datapath commands
    csl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_cmd      (cmd)
    );

    // sign fold, time products, scaled-step divider, axis update
    csl_dp #(
        .VEL_WIDTH (VEL_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_steps (steps),
        .i_tdata (i_s_axis_tdata),
        .o_tdata (o_m_axis_tdata)
    );

endmodule
